// File: rtl/core/rgb_to_hsv_hsl_converter_core_defines.svh
// Assertion macros for the RGB to HSV/HSL converter core.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef RGB_TO_HSV_HSL_CONVERTER_CORE_DEFINES_SVH
`define RGB_TO_HSV_HSL_CONVERTER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define RHC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
`define RHC_ASSERT_IMP(lbl, ante, cons, msg) \
  `RHC_ASSERT(lbl, (ante) |-> (cons), msg)
`else
`define RHC_ASSERT(lbl, prop, msg)
`define RHC_ASSERT_IMP(lbl, ante, cons, msg)
`endif

`endif

// File: rtl/core/rhc_pkg.sv
// Package for the RGB to HSV/HSL converter core: widths, constants, stage types.
// No dependencies.
package rhc_pkg;

  localparam int unsigned FRAC_BITS = 8;
  localparam int unsigned CH_W      = 8;
  localparam int unsigned HUE_W     = 17;
  localparam int unsigned PCT_W     = 15;

  // restoring divider width: covers 360*255*2^F plus rounding
  localparam int unsigned DIV_W     = HUE_W + FRAC_BITS;
  // level numerator: 25500*2^F + 127
  localparam int unsigned LVL_NUM_W = PCT_W + FRAC_BITS;
  // divide by 255 via reciprocal, exact for LVL_NUM_W-bit numerators
  localparam int unsigned RCP_SH    = LVL_NUM_W + CH_W;
  localparam int unsigned RCP_W     = LVL_NUM_W + 1;
  localparam int unsigned PROD_W    = LVL_NUM_W + RCP_W;
  localparam int unsigned LQ_W      = PROD_W - RCP_SH;

  localparam logic [63:0]        RCP_FULL = ((64'd1 << RCP_SH) + 64'd254) / 64'd255;
  localparam logic [RCP_W-1:0]   LVL_RCP  = RCP_FULL[RCP_W-1:0];
  localparam logic [LVL_NUM_W-1:0] LVL_RND = LVL_NUM_W'(127);

  localparam logic [DIV_W-1:0] SAT_MAX = DIV_W'(100) << FRAC_BITS;
  localparam logic [LQ_W-1:0]  LVL_MAX = LQ_W'(100) << FRAC_BITS;

  localparam logic MODE_HSV = 1'b0;
  localparam logic MODE_HSL = 1'b1;

  typedef enum logic [1:0] {
    MAX_RED,
    MAX_GREEN,
    MAX_BLUE
  } max_sel_e;

  typedef struct packed {
    logic            mode;
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
  } pix_t;

  typedef struct packed {
    logic            mode;
    logic            grey;
    max_sel_e        sel;
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
    logic [CH_W-1:0] mx;
    logic [CH_W-1:0] d;
    logic [CH_W:0]   sum;
  } ext_t;

  typedef struct packed {
    logic                 mode;
    logic                 grey;
    logic [CH_W-1:0]      d;
    logic signed [17:0]   hue_raw;
    logic [PCT_W-1:0]     sat_num;
    logic [CH_W-1:0]      sat_den;
    logic [LVL_NUM_W-1:0] lvl_num;
  } num_t;

  typedef struct packed {
    logic              mode;
    logic              grey;
    logic [DIV_W-1:0]  hue_num;
    logic [CH_W-1:0]   hue_den;
    logic [DIV_W-1:0]  sat_num;
    logic [CH_W-1:0]   sat_den;
    logic [PROD_W-1:0] lvl_prod;
  } pre_t;

  typedef struct packed {
    logic             mode;
    logic             grey;
    logic [PCT_W-1:0] level;
    logic [DIV_W-1:0] hue_acc;
    logic [CH_W-1:0]  hue_rem;
    logic [CH_W-1:0]  hue_den;
    logic [DIV_W-1:0] sat_acc;
    logic [CH_W-1:0]  sat_rem;
    logic [CH_W-1:0]  sat_den;
  } div_t;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [PCT_W-1:0] sat;
    logic [PCT_W-1:0] level;
    logic             mode;
  } res_t;

endpackage

// File: rtl/core/rhc_pix_if.sv
// Pixel input channel of the converter core: valid/ready plus mode and RGB.
// Depends on rhc_pkg.
interface rhc_pix_if import rhc_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            mode;
  logic [CH_W-1:0] red_in;
  logic [CH_W-1:0] green_in;
  logic [CH_W-1:0] blue_in;

  modport source (output valid, mode, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, mode, red_in, green_in, blue_in, output ready);
endinterface

// File: rtl/core/rhc_hsx_if.sv
// Result channel of the converter core: valid/ready plus hue, saturation, level.
// Depends on rhc_pkg.
interface rhc_hsx_if import rhc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [HUE_W-1:0] hue_out;
  logic [PCT_W-1:0] sat_out;
  logic [PCT_W-1:0] level_out;
  logic             mode_out;

  modport source (output valid, hue_out, sat_out, level_out, mode_out, input ready);
  modport sink   (input valid, hue_out, sat_out, level_out, mode_out, output ready);
endinterface

// File: rtl/core/rgb_to_hsv_hsl_converter_core.sv
// RGB to HSV/HSL converter core: pipelined min/max, numerators and two
// restoring dividers. Depends on rhc_pkg, rhc_pix_if, rhc_hsx_if and the defines header.
//
//   port   dir  modport  transaction
//   pix_i  in   sink     mode, red_in, green_in, blue_in
//   hsx_o  out  source   hue_out, sat_out, level_out, mode_out
//
// One transaction per cycle while the skid register is empty; the hue and saturation
// dividers retire one quotient bit per stage.
// Reset clears the valid bits, including the skid valid bit; payload is not reset.
// A stalled result goes to a one-entry skid register; while it is full the
// pipe holds and pix_i.ready is low.

`include "rgb_to_hsv_hsl_converter_core_defines.svh"

module rgb_to_hsv_hsl_converter_core import rhc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  rhc_pix_if.sink    pix_i,
  rhc_hsx_if.source  hsx_o
);

  logic             adv;
  logic             v1_q, v2_q, v3_q, v4_q;
  pix_t             s1_d, s1_q;
  ext_t             s2_d, s2_q;
  num_t             s3_d, s3_q;
  pre_t             s4_d, s4_q;
  div_t             div_head;
  div_t             div_d [DIV_W];
  div_t             div_q [DIV_W];
  logic [DIV_W-1:0] dv_vld_q;
  res_t             res_last;
  res_t             skid_q;
  logic             skid_vld_d, skid_vld_q;
  res_t             res_sel;
  logic [LQ_W-1:0]  lvl_quo;

  assign adv         = !skid_vld_q;
  assign pix_i.ready = adv;

  // stage 1: input register
  always_comb begin
    s1_d.mode = pix_i.mode;
    s1_d.r    = pix_i.red_in;
    s1_d.g    = pix_i.green_in;
    s1_d.b    = pix_i.blue_in;
  end

  // stage 2: max, min, difference
  always_comb begin
    logic [CH_W-1:0] mx;
    logic [CH_W-1:0] mn;
    mx = s1_q.r;
    mn = s1_q.r;
    if (s1_q.g > mx) mx = s1_q.g;
    if (s1_q.b > mx) mx = s1_q.b;
    if (s1_q.g < mn) mn = s1_q.g;
    if (s1_q.b < mn) mn = s1_q.b;
    s2_d.mode = s1_q.mode;
    s2_d.r    = s1_q.r;
    s2_d.g    = s1_q.g;
    s2_d.b    = s1_q.b;
    s2_d.mx   = mx;
    s2_d.d    = mx - mn;
    s2_d.grey = (mx == mn);
    s2_d.sum  = {1'b0, mx} + {1'b0, mn};
    if (s1_q.r == mx) begin
      s2_d.sel = MAX_RED;
    end else if (s1_q.g == mx) begin
      s2_d.sel = MAX_GREEN;
    end else begin
      s2_d.sel = MAX_BLUE;
    end
  end

  // stage 3: raw numerators and divisors
  always_comb begin
    logic signed [17:0] rs, gs, bs, ds, diff;
    logic [PCT_W-1:0]   lvl_x;
    rs = $signed({10'd0, s2_q.r});
    gs = $signed({10'd0, s2_q.g});
    bs = $signed({10'd0, s2_q.b});
    ds = $signed({10'd0, s2_q.d});
    case (s2_q.sel)
      MAX_RED:   diff = gs - bs;
      MAX_GREEN: diff = (ds <<< 1) + bs - rs;
      MAX_BLUE:  diff = (ds <<< 2) + rs - gs;
      default:   diff = '0;
    endcase
    if (s2_q.mode == MODE_HSL) begin
      lvl_x = PCT_W'(s2_q.sum) * PCT_W'(50);
    end else begin
      lvl_x = PCT_W'(s2_q.mx) * PCT_W'(100);
    end
    if (s2_q.mode == MODE_HSV) begin
      s3_d.sat_den = s2_q.mx;
    end else if (s2_q.sum < 9'd255) begin
      s3_d.sat_den = s2_q.sum[CH_W-1:0];
    end else begin
      s3_d.sat_den = CH_W'(9'd510 - s2_q.sum);
    end
    s3_d.mode    = s2_q.mode;
    s3_d.grey    = s2_q.grey;
    s3_d.d       = s2_q.d;
    s3_d.hue_raw = diff * 18'sd60;
    s3_d.sat_num = PCT_W'(s2_q.d) * PCT_W'(100);
    s3_d.lvl_num = (LVL_NUM_W'(lvl_x) << FRAC_BITS) + LVL_RND;
  end

  // stage 4: hue wrap, scaling with rounding, level reciprocal product
  always_comb begin
    logic [HUE_W-1:0] hue360;
    logic [18:0]      hsum;
    hue360 = HUE_W'(s3_q.d) * HUE_W'(360);
    hsum   = {s3_q.hue_raw[17], s3_q.hue_raw}
           + (s3_q.hue_raw[17] ? {2'b00, hue360} : 19'd0);
    s4_d.mode     = s3_q.mode;
    s4_d.grey     = s3_q.grey;
    s4_d.hue_num  = (DIV_W'(hsum[HUE_W-1:0]) << FRAC_BITS) + DIV_W'(s3_q.d >> 1);
    s4_d.hue_den  = s3_q.d;
    s4_d.sat_num  = (DIV_W'(s3_q.sat_num) << FRAC_BITS) + DIV_W'(s3_q.sat_den >> 1);
    s4_d.sat_den  = s3_q.sat_den;
    s4_d.lvl_prod = PROD_W'(s3_q.lvl_num) * PROD_W'(LVL_RCP);
  end

  assign lvl_quo = s4_q.lvl_prod[PROD_W-1:RCP_SH];

  always_comb begin
    div_head.mode    = s4_q.mode;
    div_head.grey    = s4_q.grey;
    div_head.level   = lvl_quo[PCT_W-1:0];
    div_head.hue_acc = s4_q.hue_num;
    div_head.hue_rem = '0;
    div_head.hue_den = s4_q.hue_den;
    div_head.sat_acc = s4_q.sat_num;
    div_head.sat_rem = '0;
    div_head.sat_den = s4_q.sat_den;
  end

  // restoring divider stages, one quotient bit each
  for (genvar k = 0; k < DIV_W; k++) begin : g_div
    div_t src;
    if (k == 0) begin : g_head
      assign src = div_head;
    end else begin : g_body
      assign src = div_q[k-1];
    end

    always_comb begin
      logic [CH_W:0] hp, sp, hdf, sdf;
      logic          hge, sge;
      hp  = {src.hue_rem, src.hue_acc[DIV_W-1]};
      sp  = {src.sat_rem, src.sat_acc[DIV_W-1]};
      hdf = hp - {1'b0, src.hue_den};
      sdf = sp - {1'b0, src.sat_den};
      hge = (hp >= {1'b0, src.hue_den});
      sge = (sp >= {1'b0, src.sat_den});
      div_d[k]         = src;
      div_d[k].hue_rem = hge ? hdf[CH_W-1:0] : hp[CH_W-1:0];
      div_d[k].hue_acc = {src.hue_acc[DIV_W-2:0], hge};
      div_d[k].sat_rem = sge ? sdf[CH_W-1:0] : sp[CH_W-1:0];
      div_d[k].sat_acc = {src.sat_acc[DIV_W-2:0], sge};
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        div_q[k] <= div_d[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
      s3_q <= s3_d;
      s4_q <= s4_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      v3_q     <= 1'b0;
      v4_q     <= 1'b0;
      dv_vld_q <= '0;
    end else if (adv) begin
      v1_q     <= pix_i.valid;
      v2_q     <= v1_q;
      v3_q     <= v2_q;
      v4_q     <= v3_q;
      dv_vld_q <= {dv_vld_q[DIV_W-2:0], v4_q};
    end
  end

  // result formatting and output skid
  always_comb begin
    res_last.hue   = div_q[DIV_W-1].grey ? '0 : div_q[DIV_W-1].hue_acc[HUE_W-1:0];
    res_last.sat   = div_q[DIV_W-1].grey ? '0 : div_q[DIV_W-1].sat_acc[PCT_W-1:0];
    res_last.level = div_q[DIV_W-1].level;
    res_last.mode  = div_q[DIV_W-1].mode;
  end

  always_comb begin
    if (skid_vld_q) begin
      skid_vld_d = !hsx_o.ready;
    end else begin
      skid_vld_d = dv_vld_q[DIV_W-1] && !hsx_o.ready;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_vld_q <= 1'b0;
    end else begin
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_vld_q) begin
      skid_q <= res_last;
    end
  end

  assign res_sel         = skid_vld_q ? skid_q : res_last;
  assign hsx_o.valid     = skid_vld_q || dv_vld_q[DIV_W-1];
  assign hsx_o.hue_out   = res_sel.hue;
  assign hsx_o.sat_out   = res_sel.sat;
  assign hsx_o.level_out = res_sel.level;
  assign hsx_o.mode_out  = res_sel.mode;

  `RHC_ASSERT_IMP(a_skid_load, $rose(skid_vld_q), $past(dv_vld_q[DIV_W-1] && !hsx_o.ready), "skid loaded without a stalled result")
  `RHC_ASSERT(a_pipe_hold, skid_vld_q |=> ($stable(dv_vld_q) && $stable(v4_q)), "pipe moved while skid full")
  `RHC_ASSERT_IMP(a_lvl_range, v4_q, lvl_quo <= LVL_MAX, "level quotient above full scale")
  `RHC_ASSERT_IMP(a_sat_range, dv_vld_q[DIV_W-1] && !div_q[DIV_W-1].grey, div_q[DIV_W-1].sat_acc <= SAT_MAX, "saturation quotient above full scale")

endmodule
